[hdl/hpe_pkg.sv]
// Shared types and constants for the Hoare partition engine.
package hpe_pkg;

  // Fixed field widths of the stream payload.
  localparam int ACT_W    = 2;
  localparam int POS_W    = 10;
  localparam int KEYIO_W  = 32;
  localparam int STATUS_W = 2;
  localparam int IN_TDATA_W  = 56;  // position, range_end, key_in, zero pad
  localparam int OUT_TDATA_W = 48;  // key_out, split_index, status, zero pad

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_PART  = 2'd1,
    ACT_READ  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_SENTINEL = 2'd1,
    STS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK_HI,
    ST_CHK_CMP,
    ST_I_RD,
    ST_I_CMP,
    ST_J_RD,
    ST_J_CMP,
    ST_FJ_CHK,
    ST_FJ_CMP,
    ST_SW_A,
    ST_SW_B,
    ST_FIN
  } state_t;

  // Configuration register indexes.
  localparam logic CFG_PIVOT_FIRST = 1'b0;
  localparam logic CFG_SIGNED_KEYS = 1'b1;

endpackage

[hdl/hpe_key_ram.sv]
// Key store: one write port, one read port with registered read data.
module hpe_key_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int KW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [KW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [KW-1:0] rdata
);

  logic [KW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/hpe_cmp.sv]
// Shared key comparator: lt is high when a is ordered strictly before b.
module hpe_cmp #(
  parameter int KW = 32
) (
  input  logic [KW-1:0] a,
  input  logic [KW-1:0] b,
  input  logic          signed_mode,
  output logic          lt
);

  logic [KW-1:0] a_m;
  logic [KW-1:0] b_m;

  // flipping the sign bit maps two's complement order onto unsigned order
  assign a_m = {a[KW-1] ^ signed_mode, a[KW-2:0]};
  assign b_m = {b[KW-1] ^ signed_mode, b[KW-2:0]};
  assign lt  = a_m < b_m;

endmodule

[hdl/hoare_partition_engine.sv]
// Top level: command decode, partition sequencer and result register.
//
//  channel | direction | payload
//  --------+-----------+-----------------------------------------------------
//  in_     | slave     | tuser: action; tdata: position, range_end, key_in
//  out_    | master    | tdata: key_out, split_index, status
//  cfg_    | write     | index 0 pivot_at_first, index 1 signed_keys
//
// Sequencing: a partition first checks the two end keys, then runs the scans and
// the swaps; the sequencer makes one key store access per state and shares one
// comparator, so each key visited and each swap takes states of its own.
// Reset: rst_n synchronous, active low; clears control and config, not keys.
// Stalls: one finished result waits in the output register while the next
// transaction is taken; a second finished result holds the sequencer in its
// final state until out_tready.
module hoare_partition_engine
  import hpe_pkg::*;
#(
  parameter int STORE_DEPTH = 1024,
  parameter int KEY_BITS    = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // tdata bits from bit 0: position[9:0], range_end[19:10], key_in[51:20], pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser bits from bit 0: action[1:0]
  input  logic [ACT_W-1:0]       in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // tdata bits from bit 0: key_out[31:0], split_index[41:32], status[43:42], pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic                   cfg_wdata
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int KW = KEY_BITS;

  // ---------------------------------------------------------------- config
  logic pivot_first_r;
  logic signed_keys_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_first_r <= 1'b0;
      signed_keys_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PIVOT_FIRST: pivot_first_r <= cfg_wdata;
        CFG_SIGNED_KEYS: signed_keys_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- input decode
  logic [POS_W-1:0]   in_pos;
  logic [POS_W-1:0]   in_end;
  logic [KEYIO_W-1:0] in_key;
  logic [31:0]        pos_ext;
  logic [31:0]        end_ext;
  logic [63:0]        key_ext;
  logic [AW-1:0]      pos_idx;
  logic [AW-1:0]      end_idx;
  logic               pos_ok;
  logic               range_bad;
  logic               in_fire;

  assign in_pos    = in_tdata[9:0];
  assign in_end    = in_tdata[19:10];
  assign in_key    = in_tdata[51:20];
  assign pos_ext   = 32'(in_pos);
  assign end_ext   = 32'(in_end);
  assign key_ext   = 64'(in_key);
  assign pos_idx   = pos_ext[AW-1:0];
  assign end_idx   = end_ext[AW-1:0];
  assign pos_ok    = pos_ext < 32'(STORE_DEPTH);
  assign range_bad = (end_ext <= pos_ext) || (end_ext >= 32'(STORE_DEPTH));

  // ------------------------------------------------------------- registers
  state_t        state_r, state_nxt;
  logic [AW-1:0] lo_r, lo_nxt;
  logic [AW-1:0] hi_r, hi_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [KW-1:0] pivot_r, pivot_nxt;
  logic [KW-1:0] key_i_r, key_i_nxt;
  logic [KW-1:0] key_j_r, key_j_nxt;
  logic          first_phase_r, first_phase_nxt;  // first-pivot opening scan
  status_t       res_status_r, res_status_nxt;
  logic [AW-1:0] res_split_r, res_split_nxt;
  logic          res_rd_r, res_rd_nxt;            // key_out comes from store
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic          out_tvalid_r, out_tvalid_nxt;

  // ---------------------------------------------------------- shared units
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [KW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [KW-1:0] ram_rdata;
  logic [KW-1:0] cmp_a;
  logic [KW-1:0] cmp_b;
  logic          cmp_lt;

  hpe_key_ram #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW),
    .KW    (KW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sentinel check compares the two end keys; scans compare against pivot
  always_comb begin
    cmp_a = ram_rdata;
    cmp_b = pivot_r;
    if (state_r == ST_CHK_CMP) begin
      cmp_a = pivot_first_r ? ram_rdata : key_i_r;
      cmp_b = pivot_first_r ? key_i_r : ram_rdata;
    end
  end

  hpe_cmp #(
    .KW (KW)
  ) u_cmp (
    .a           (cmp_a),
    .b           (cmp_b),
    .signed_mode (signed_keys_r),
    .lt          (cmp_lt)
  );

  // -------------------------------------------------------------- handshake
  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  logic          out_free;
  logic [63:0]   rd_ext;
  logic [31:0]   split_ext;
  logic [KEYIO_W-1:0] key_res;

  assign out_free  = !out_tvalid_r || out_tready;
  assign rd_ext    = 64'(ram_rdata);
  assign split_ext = 32'(res_split_r);
  assign key_res   = res_rd_r ? rd_ext[KEYIO_W-1:0] : '0;

  // ------------------------------------------------------------ next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (action_t'(in_tuser) == ACT_PART && !range_bad) begin
            state_nxt = ST_CHK_HI;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_CHK_HI:  state_nxt = ST_CHK_CMP;
      ST_CHK_CMP: begin
        if (pivot_first_r ? cmp_lt : !cmp_lt) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_I_RD;
        end
      end
      ST_I_RD: begin
        if (i_r < hi_r) begin
          state_nxt = ST_I_CMP;
        end else begin
          state_nxt = first_phase_r ? ST_FJ_CHK : ST_J_RD;
        end
      end
      ST_I_CMP: begin
        if (cmp_lt) begin
          state_nxt = ST_I_RD;
        end else begin
          state_nxt = first_phase_r ? ST_FJ_CHK : ST_J_RD;
        end
      end
      ST_J_RD: begin
        if (j_r > lo_r) begin
          state_nxt = ST_J_CMP;
        end else begin
          state_nxt = (i_r < j_r) ? ST_SW_A : ST_FIN;
        end
      end
      ST_J_CMP: begin
        if (!cmp_lt) begin
          state_nxt = ST_J_RD;
        end else begin
          state_nxt = (i_r < j_r) ? ST_SW_A : ST_FIN;
        end
      end
      ST_FJ_CHK: begin
        state_nxt = (j_r < i_r) ? ST_FIN : ST_FJ_CMP;
      end
      ST_FJ_CMP: begin
        if (cmp_lt) begin
          state_nxt = (j_r < i_r) ? ST_FIN : ST_SW_A;
        end else begin
          state_nxt = ST_FJ_CHK;
        end
      end
      ST_SW_A: state_nxt = ST_SW_B;
      ST_SW_B: state_nxt = ST_I_RD;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = i_r;
    ram_wdata       = key_j_r;
    ram_re          = 1'b0;
    ram_raddr       = i_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    i_nxt           = i_r;
    j_nxt           = j_r;
    pivot_nxt       = pivot_r;
    key_i_nxt       = key_i_r;
    key_j_nxt       = key_j_r;
    first_phase_nxt = first_phase_r;
    res_status_nxt  = res_status_r;
    res_split_nxt   = res_split_r;
    res_rd_nxt      = res_rd_r;
    out_tdata_nxt   = out_tdata_r;
    out_tvalid_nxt  = out_tvalid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_status_nxt = STS_OK;
          res_split_nxt  = '0;
          res_rd_nxt     = 1'b0;
          case (action_t'(in_tuser))
            ACT_WRITE: begin
              ram_we    = pos_ok;
              ram_waddr = pos_idx;
              ram_wdata = key_ext[KW-1:0];
            end
            ACT_READ: begin
              ram_re     = pos_ok;
              ram_raddr  = pos_idx;
              res_rd_nxt = pos_ok;
            end
            ACT_PART: begin
              if (range_bad) begin
                res_status_nxt = STS_RANGE;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = pos_idx;
                lo_nxt    = pos_idx;
                hi_nxt    = end_idx;
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHK_HI: begin
        key_i_nxt = ram_rdata;          // key at the low end
        ram_re    = 1'b1;
        ram_raddr = hi_r;
      end
      ST_CHK_CMP: begin
        if (pivot_first_r ? cmp_lt : !cmp_lt) begin
          res_status_nxt = STS_SENTINEL;
        end else begin
          pivot_nxt       = pivot_first_r ? key_i_r : ram_rdata;
          i_nxt           = AW'(lo_r + 1'b1);
          j_nxt           = hi_r;
          first_phase_nxt = pivot_first_r;
        end
      end
      ST_I_RD: begin
        if (i_r < hi_r) begin
          ram_re    = 1'b1;
          ram_raddr = i_r;
        end else if (!first_phase_r) begin
          j_nxt = AW'(j_r - 1'b1);
        end
      end
      ST_I_CMP: begin
        if (cmp_lt) begin
          i_nxt = AW'(i_r + 1'b1);
        end else begin
          key_i_nxt = ram_rdata;
          if (!first_phase_r) begin
            j_nxt = AW'(j_r - 1'b1);
          end
        end
      end
      ST_J_RD: begin
        if (j_r > lo_r) begin
          ram_re    = 1'b1;
          ram_raddr = j_r;
        end else if (!(i_r < j_r)) begin
          res_split_nxt = j_r;
        end
      end
      ST_J_CMP: begin
        if (!cmp_lt) begin
          j_nxt = AW'(j_r - 1'b1);
        end else begin
          key_j_nxt = ram_rdata;
          if (!(i_r < j_r)) begin
            res_split_nxt = j_r;
          end
        end
      end
      ST_FJ_CHK: begin
        if (j_r < i_r) begin
          res_split_nxt = j_r;
        end else begin
          j_nxt     = AW'(j_r - 1'b1);
          ram_re    = 1'b1;
          ram_raddr = AW'(j_r - 1'b1);
        end
      end
      ST_FJ_CMP: begin
        if (cmp_lt) begin
          key_j_nxt       = ram_rdata;
          first_phase_nxt = 1'b0;
          if (j_r < i_r) begin
            res_split_nxt = j_r;
          end
        end
      end
      ST_SW_A: begin
        ram_we    = 1'b1;
        ram_waddr = i_r;
        ram_wdata = key_j_r;
      end
      ST_SW_B: begin
        ram_we    = 1'b1;
        ram_waddr = j_r;
        ram_wdata = key_i_r;
        i_nxt     = AW'(i_r + 1'b1);
      end
      ST_FIN: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {4'b0, res_status_r, split_ext[POS_W-1:0], key_res};
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------ sequential
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    i_r           <= i_nxt;
    j_r           <= j_nxt;
    pivot_r       <= pivot_nxt;
    key_i_r       <= key_i_nxt;
    key_j_r       <= key_j_nxt;
    first_phase_r <= first_phase_nxt;
    res_status_r  <= res_status_nxt;
    res_split_r   <= res_split_nxt;
    res_rd_r      <= res_rd_nxt;
    out_tdata_r   <= out_tdata_nxt;
  end

  // ------------------------------------------------------------ assertions
  a_i_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_I_RD || state_r == ST_I_CMP || state_r == ST_J_RD ||
     state_r == ST_J_CMP) |-> (i_r <= hi_r))
    else $error("left scan ran past the range end");

  a_j_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_J_RD || state_r == ST_J_CMP) |-> (j_r >= lo_r))
    else $error("right scan ran below the range start");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SW_A) |-> (i_r < j_r))
    else $error("swap issued with crossed indexes");

  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_IDLE || state_r == ST_SW_A || state_r == ST_SW_B))
    else $error("key store written outside a write or a swap");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the final state");

endmodule

[test/tb_hoare_partition_engine.sv]
// Self-checking testbench for the Hoare partition engine: stream stimulus and scoreboard.
module tb_hoare_partition_engine;
  import hpe_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int KEY_BITS    = 32;
  localparam int STALL_LIMIT = 20000;  // watchdog limit, well above the longest partition here
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;  // undefined opcode, gives a zero result

  // One expected result, field by field; logic so that X on the port shows up.
  typedef struct packed {
    logic [KEYIO_W-1:0]  key;
    logic [POS_W-1:0]    split;
    logic [STATUS_W-1:0] status;
  } result_t;

  // Scoreboard: private copy of the key store and config, Hoare partition predictor,
  // and the in-order queue of expected results.
  class partition_scoreboard;
    bit [KEY_BITS-1:0] store [STORE_DEPTH];
    bit                pivot_first;
    bit                signed_order;
    result_t           pending_q[$];
    int                mismatches;
    int                checked;
    int                partitions;
    int                broken;
    int                bad_ranges;

    function bit precedes(bit [KEY_BITS-1:0] a, bit [KEY_BITS-1:0] b);
      if (signed_order) return $signed(a) < $signed(b);
      return a < b;
    endfunction

    function void swap_keys(int a, int b);
      bit [KEY_BITS-1:0] t;
      t = store[a];
      store[a] = store[b];
      store[b] = t;
    endfunction

    // Crossing scans from both ends, each bounded to the range; returns the split.
    function int crossing_scan(int lo, int hi, int i, int j, bit [KEY_BITS-1:0] pivot);
      int split_at;
      split_at = -1;
      while (split_at < 0) begin
        i++;
        while (i < hi && precedes(store[i], pivot)) i++;
        j--;
        while (j > lo && !precedes(store[j], pivot)) j--;
        if (i < j) swap_keys(i, j);
        else split_at = j;
      end
      return split_at;
    endfunction

    // First-element pivot: lower part may end up holding only the pivot.
    function int split_first_pivot(int lo, int hi);
      bit [KEY_BITS-1:0] pivot;
      int i;
      int j;
      bit done;
      pivot = store[lo];
      i = lo + 1;
      j = hi;
      done = 1'b0;
      while (i < hi && precedes(store[i], pivot)) i++;
      while (!done) begin
        if (j < i) done = 1'b1;
        else begin
          j--;
          if (precedes(store[j], pivot)) done = 1'b1;
        end
      end
      if (j < i) return j;
      swap_keys(i, j);
      return crossing_scan(lo, hi, i, j, pivot);
    endfunction

    // Called on every accepted input transaction.
    function void note_input(bit [ACT_W-1:0] act, bit [POS_W-1:0] pos, bit [POS_W-1:0] last,
                             bit [KEYIO_W-1:0] key);
      result_t r;
      int lo;
      int hi;
      r = '0;
      lo = pos;
      hi = last;
      case (act)
        ACT_WRITE: store[pos] = key;
        ACT_READ:  r.key = store[pos];
        ACT_PART: begin
          partitions++;
          if (hi <= lo) begin
            r.status = STS_RANGE;
            bad_ranges++;
          end else if (pivot_first ? precedes(store[hi], store[lo])
                                   : !precedes(store[lo], store[hi])) begin
            r.status = STS_SENTINEL;
            broken++;
          end else if (pivot_first) begin
            r.split = 10'(split_first_pivot(lo, hi));
          end else begin
            r.split = 10'(crossing_scan(lo, hi, lo, hi, store[hi]));
          end
        end
        default: ;
      endcase
      pending_q.push_back(r);
    endfunction

    // Called on every accepted output transaction.
    function void check_result(logic [OUT_TDATA_W-1:0] data);
      result_t got;
      result_t want;
      got.key    = data[31:0];
      got.split  = data[41:32];
      got.status = data[43:42];
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: key %h split %0d status %0d",
                   got.key, got.split, got.status);
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.key !== want.key || got.split !== want.split || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected key %h split %0d status %0d, got key %h split %0d status %0d",
                   want.key, want.split, want.status, got.key, got.split, got.status);
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [ACT_W-1:0]       in_tuser = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic                   cfg_index = 1'b0;
  logic                   cfg_wdata = 1'b0;

  partition_scoreboard sb;
  int  snd_idle_pct = 0;   // chance in percent that the sender inserts an idle cycle
  int  rcv_idle_pct = 0;   // chance in percent that the receiver holds off out_tready
  int  items_sent = 0;     // counts transactions that do real work
  int  stall_cycles = 0;
  bit  written [STORE_DEPTH];
  int  written_q[$];       // indexes that hold a defined key

  hoare_partition_engine #(
    .STORE_DEPTH(STORE_DEPTH),
    .KEY_BITS   (KEY_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Receiver backpressure; drives only on the falling edge.
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= rcv_idle_pct);
  end

  // Output monitor: sampled at the rising edge, before the DUT's NBAs land.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Watchdog: any transaction on either stream restarts the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Drive one input transaction. Random idle cycles go in front of it; tvalid stays
  // high across back-to-back transactions.
  task automatic send_txn(input logic [ACT_W-1:0] act, input int pos, input int last,
                          input logic [KEYIO_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tuser  = act;
    in_tdata  = {4'b0, key, 10'(last), 10'(pos)};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_input(act, 10'(pos), 10'(last), key);
    if (act != ACT_UNUSED) items_sent++;
  endtask

  task automatic write_key(input int pos, input logic [KEYIO_W-1:0] key);
    send_txn(ACT_WRITE, pos, $urandom_range(1023), key);
    if (!written[pos]) begin
      written[pos] = 1'b1;
      written_q.push_back(pos);
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic idx, input logic val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Config only changes with the engine idle: input stopped, all results back.
  task automatic drain_and_configure(input bit pivot_first, input bit signed_order);
    stop_input();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    write_reg(CFG_PIVOT_FIRST, pivot_first);
    write_reg(CFG_SIGNED_KEYS, signed_order);
    sb.pivot_first  = pivot_first;
    sb.signed_order = signed_order;
  endtask

  // Key mix: full random, corner values, and tight clusters so duplicates are common.
  function automatic logic [KEYIO_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom;
      1: case ($urandom_range(3))
           0:       return 32'h0000_0000;
           1:       return 32'hFFFF_FFFF;
           2:       return 32'h8000_0000;
           default: return 32'h7FFF_FFFF;
         endcase
      2: return 32'($urandom_range(6)) - 32'd3;          // around zero, both signs
      default: return {2'($urandom_range(3)), 30'($urandom_range(3))};  // near sign edges
    endcase
  endfunction

  // Well-formed job: fill a range, mostly with the end keys in legal order, partition,
  // read some back, sometimes partition a sub-range of the result.
  task automatic run_partition_seq();
    logic [KEYIO_W-1:0] vals [128];
    logic [KEYIO_W-1:0] t;
    int len;
    int lo;
    int hi;
    int a;
    int b;
    int n;
    len = ($urandom_range(24) == 0) ? $urandom_range(40, 128) : $urandom_range(2, 16);
    lo  = $urandom_range(STORE_DEPTH - len);
    hi  = lo + len - 1;
    for (int k = 0; k < len; k++) vals[k] = pick_key();
    // Fix the sentinel order most of the time; equal ends in last-pivot mode stay broken.
    if ($urandom_range(9) != 0 &&
        (sb.pivot_first ? sb.precedes(vals[len-1], vals[0])
                        : !sb.precedes(vals[0], vals[len-1]))) begin
      t = vals[0];
      vals[0] = vals[len-1];
      vals[len-1] = t;
    end
    for (int k = 0; k < len; k++) write_key(lo + k, vals[k]);
    send_txn(ACT_PART, lo, hi, $urandom);
    n = $urandom_range(3);
    repeat (n) send_txn(ACT_READ, lo + $urandom_range(len - 1), $urandom_range(1023), $urandom);
    if ($urandom_range(1)) begin
      a = lo + $urandom_range(len - 2);
      b = a + 1 + $urandom_range(hi - a - 1);
      send_txn(ACT_PART, a, b, $urandom);
    end
  endtask

  // Noise: unused opcode, bad ranges, stray writes, reads, partitions of old data.
  task automatic run_noise();
    int p;
    int lo;
    int hi;
    int target;
    case ($urandom_range(4))
      0: send_txn(ACT_UNUSED, $urandom_range(1023), $urandom_range(1023), $urandom);
      1: begin
        p = $urandom_range(1023);
        send_txn(ACT_PART, p, $urandom_range(p), $urandom);  // range_end <= position
      end
      2: write_key($urandom_range(1023), pick_key());
      3: if (written_q.size() != 0)
           send_txn(ACT_READ, written_q[$urandom_range(written_q.size() - 1)],
                    $urandom_range(1023), $urandom);
      default: if (written_q.size() != 0) begin
        lo = written_q[$urandom_range(written_q.size() - 1)];
        hi = lo;
        target = lo + $urandom_range(1, 24);
        while (hi < target && hi < STORE_DEPTH - 1 && written[hi + 1]) hi++;
        if (hi > lo) send_txn(ACT_PART, lo, hi, $urandom);
        else send_txn(ACT_READ, lo, $urandom_range(1023), $urandom);
      end
    endcase
  endtask

  // Directed: field extremes, every opcode, broken sentinel, bad ranges, unused opcode.
  // Runs with unsigned keys and last-element pivot.
  task automatic run_directed();
    write_key(0, 32'h0000_0005);
    write_key(1, 32'hFFFF_FFFF);
    write_key(2, 32'h8000_0000);
    write_key(3, 32'h7FFF_FFFF);
    write_key(4, 32'h0000_0003);
    write_key(1023, 32'hA5A5_A5A5);
    write_key(1022, 32'h5A5A_5A5A);
    send_txn(ACT_READ, 1023, 1023, 32'hFFFF_FFFF);
    send_txn(ACT_READ, 0, 0, 32'h0);
    send_txn(ACT_PART, 0, 4, 32'h0);            // first key not below pivot
    write_key(0, 32'h0000_0000);
    send_txn(ACT_PART, 0, 4, 32'hFFFF_FFFF);    // legal now
    send_txn(ACT_READ, 1, 0, 32'h0);
    send_txn(ACT_READ, 4, 0, 32'h0);
    send_txn(ACT_PART, 1022, 1023, 32'h0);      // two-key range at the top of the store
    send_txn(ACT_PART, 5, 5, 32'h0);            // empty range
    send_txn(ACT_PART, 1023, 0, 32'h0);         // reversed range
    send_txn(ACT_PART, 1023, 1023, 32'h0);
    send_txn(ACT_UNUSED, 1023, 1023, 32'hFFFF_FFFF);
    send_txn(ACT_UNUSED, 0, 0, 32'h0);
  endtask

  initial begin
    int seg_end;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    drain_and_configure(1'b0, 1'b0);
    run_directed();
    // Three stall profiles, each sweeping all four pivot/key-order settings.
    for (int prof = 0; prof < 3; prof++) begin
      case (prof)
        0: begin snd_idle_pct = 16; rcv_idle_pct = 61; end
        1: begin snd_idle_pct = 61; rcv_idle_pct = 16; end
        default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
      endcase
      for (int c = 0; c < 4; c++) begin
        drain_and_configure(c[0], c[1]);
        seg_end = items_sent + 100;
        while (items_sent < seg_end) begin
          if ($urandom_range(9) < 7) run_partition_seq();
          else run_noise();
        end
      end
    end
    stop_input();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("ran %0d transactions, %0d results compared; %0d partitions (%0d broken sentinel, %0d bad range)",
             items_sent, sb.checked, sb.partitions, sb.broken, sb.bad_ranges);
    $display("covered both pivot modes, both key orders and three stall profiles; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[hoare_partition_engine.f]
hdl/hpe_pkg.sv
hdl/hpe_key_ram.sv
hdl/hpe_cmp.sv
hdl/hoare_partition_engine.sv
test/tb_hoare_partition_engine.sv
